/* sv/stdpt_pkg.sv */
// ----------------------------------------------------------------------------
// stdpt_pkg
// Shared types and constants for the sieve trial-division prime tester.
// ----------------------------------------------------------------------------
package stdpt_pkg;

  localparam int NUM_W  = 31;   // tested number
  localparam int CNT_W  = 16;   // candidate, root and limit
  localparam int STEP_W = 5;    // bit position within the number
  localparam int JJ_W   = 17;   // strike/fill pointer, holds limit + candidate
  localparam int SQ_W   = 32;   // candidate squared

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQRT,
    S_ROUND,
    S_FILL_START,
    S_FILL,
    S_CAND_START,
    S_READ,
    S_TEST,
    S_DIV,
    S_DIV_END,
    S_STRIKE_START,
    S_STRIKE,
    S_DONE
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SQRT,
    OP_ROUND,
    OP_FILL_START,
    OP_FILL,
    OP_CAND_START,
    OP_READ,
    OP_DIV_START,
    OP_DIV,
    OP_NEXT,
    OP_PASS,
    OP_FAIL,
    OP_STRIKE_START,
    OP_STRIKE,
    OP_EMIT
  } op_t;

  typedef struct packed {
    logic sqrt_last;  // last root bit being tried
    logic j_done;     // pointer past limit or past the sieve
    logic cand_done;  // candidate past limit
    logic unmarked;   // candidate still set in the sieve or beyond it
    logic div_last;   // last remainder step
    logic composite;  // proper divisor found
    logic sq_over;    // candidate squared past limit
    logic out_free;   // result register can take an item
  } stat_t;

endpackage

/* sv/stdpt_ctrl.sv */
// ----------------------------------------------------------------------------
// stdpt_ctrl
// Sequencer: square root, sieve fill, candidate scan, trial remainder,
// striking of multiples and hand-off of the result.
// ----------------------------------------------------------------------------
module stdpt_ctrl
  import stdpt_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  s_tvalid,
  output logic  s_tready,
  input  stat_t stat,
  output op_t   op
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:         if (s_tvalid) state_next = S_SQRT;
      S_SQRT:         if (stat.sqrt_last) state_next = S_ROUND;
      S_ROUND:        state_next = S_FILL_START;
      S_FILL_START:   state_next = S_FILL;
      S_FILL:         if (stat.j_done) state_next = S_CAND_START;
      S_CAND_START:   state_next = S_READ;
      S_READ:         state_next = stat.cand_done ? S_DONE : S_TEST;
      S_TEST:         state_next = stat.unmarked ? S_DIV : S_READ;
      S_DIV:          if (stat.div_last) state_next = S_DIV_END;
      S_DIV_END:      state_next = stat.composite ? S_DONE : S_STRIKE_START;
      S_STRIKE_START: state_next = stat.sq_over ? S_READ : S_STRIKE;
      S_STRIKE:       if (stat.j_done) state_next = S_READ;
      S_DONE:         if (stat.out_free) state_next = S_IDLE;
      default:        state_next = S_IDLE;
    endcase
  end

  always_comb begin
    op       = OP_NONE;
    s_tready = 1'b0;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) op = OP_LOAD;
      end
      S_SQRT:         op = OP_SQRT;
      S_ROUND:        op = OP_ROUND;
      S_FILL_START:   op = OP_FILL_START;
      S_FILL:         op = stat.j_done ? OP_NONE : OP_FILL;
      S_CAND_START:   op = OP_CAND_START;
      S_READ:         op = stat.cand_done ? OP_NONE : OP_READ;
      S_TEST:         op = stat.unmarked ? OP_DIV_START : OP_NEXT;
      S_DIV:          op = OP_DIV;
      S_DIV_END:      op = stat.composite ? OP_FAIL : OP_PASS;
      S_STRIKE_START: op = stat.sq_over ? OP_NEXT : OP_STRIKE_START;
      S_STRIKE:       op = stat.j_done ? OP_NEXT : OP_STRIKE;
      S_DONE:         op = stat.out_free ? OP_EMIT : OP_NONE;
      default:        op = OP_NONE;
    endcase
  end

endmodule

/* sv/stdpt_dpath.sv */
// ----------------------------------------------------------------------------
// stdpt_dpath
// Datapath: bitwise root, bit-serial remainder, sieve memory with one write
// and one registered read port, and the result register.
// ----------------------------------------------------------------------------
module stdpt_dpath
  import stdpt_pkg::*;
#(
  parameter int SIEVE_DEPTH = 65536
) (
  input  logic             clk,
  input  logic             rst,
  input  op_t              op,
  output stat_t            stat,
  input  logic [NUM_W-1:0] number,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic             is_prime
);

  localparam int IDX_W = $clog2(SIEVE_DEPTH);

  logic [NUM_W-1:0]  num;
  logic [CNT_W-1:0]  root;
  logic [CNT_W-1:0]  rbit;
  logic [CNT_W-1:0]  lim;
  logic [CNT_W-1:0]  idx;
  logic [CNT_W-1:0]  rem;
  logic [STEP_W-1:0] step;
  logic [JJ_W-1:0]   jj;
  logic [SQ_W-1:0]   sq;
  logic              prime;
  logic              rd;
  logic              rd_out;

  logic              mem [SIEVE_DEPTH];

  logic [CNT_W-1:0]  trial;
  logic [SQ_W-1:0]   trial_sq;
  logic [SQ_W-1:0]   root_sq;
  logic [CNT_W:0]    shifted;
  logic [CNT_W:0]    diff;
  logic              j_done;

  assign trial    = root | rbit;
  assign trial_sq = SQ_W'(trial) * SQ_W'(trial);
  assign root_sq  = SQ_W'(root) * SQ_W'(root);
  assign shifted  = {rem, num[step]};
  assign diff     = shifted - {1'b0, idx};
  assign j_done   = (jj > {1'b0, lim}) || (jj >= JJ_W'(SIEVE_DEPTH));

  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD: begin
        num  <= number;
        root <= '0;
        rbit <= CNT_W'(1) << (CNT_W - 1);
      end
      OP_SQRT: begin
        if (trial_sq <= {1'b0, num}) root <= trial;
        rbit <= rbit >> 1;
      end
      OP_ROUND:        lim <= (root_sq < {1'b0, num}) ? root + CNT_W'(1) : root;
      OP_FILL_START:   jj  <= JJ_W'(2);
      OP_FILL:         jj  <= jj + JJ_W'(1);
      OP_CAND_START:   idx <= CNT_W'(2);
      OP_NEXT:         idx <= idx + CNT_W'(1);
      OP_DIV_START: begin
        rem  <= '0;
        step <= STEP_W'(NUM_W - 1);
      end
      OP_DIV: begin
        rem  <= diff[CNT_W] ? shifted[CNT_W-1:0] : diff[CNT_W-1:0];
        step <= step - STEP_W'(1);
      end
      OP_PASS:         sq <= SQ_W'(idx) * SQ_W'(idx);
      OP_STRIKE_START: jj <= sq[JJ_W-1:0];
      OP_STRIKE:       jj <= jj + JJ_W'(idx);
      default: ;
    endcase
  end

  // prime flag: cleared per item and on a found divisor, set by any passing candidate
  always_ff @(posedge clk) begin
    if (rst) begin
      prime <= 1'b0;
    end else if (op == OP_LOAD || op == OP_FAIL) begin
      prime <= 1'b0;
    end else if (op == OP_PASS) begin
      prime <= 1'b1;
    end
  end

  // sieve memory
  always_ff @(posedge clk) begin
    if (op == OP_FILL) begin
      mem[jj[IDX_W-1:0]] <= 1'b1;
    end else if (op == OP_STRIKE) begin
      mem[jj[IDX_W-1:0]] <= 1'b0;
    end
    if (op == OP_READ) begin
      rd     <= mem[idx[IDX_W-1:0]];
      rd_out <= {1'b0, idx} >= JJ_W'(SIEVE_DEPTH);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (op == OP_EMIT) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (op == OP_EMIT) is_prime <= prime;
  end

  always_comb begin
    stat.sqrt_last = rbit[0];
    stat.j_done    = j_done;
    stat.cand_done = idx > lim;
    stat.unmarked  = rd | rd_out;
    stat.div_last  = step == '0;
    stat.composite = (rem == '0) && (num != NUM_W'(idx));
    stat.sq_over   = sq > SQ_W'(lim);
    stat.out_free  = !m_tvalid || m_tready;
  end

  a_read_in_range: assert property (@(posedge clk) disable iff (rst)
    op == OP_READ |-> idx <= lim)
    else $error("sieve read past limit");

  a_write_in_sieve: assert property (@(posedge clk) disable iff (rst)
    (op == OP_FILL || op == OP_STRIKE) |-> jj < JJ_W'(SIEVE_DEPTH))
    else $error("sieve write past depth");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    op == OP_DIV |=> rem < idx)
    else $error("remainder not below divisor");

  a_strike_from_square: assert property (@(posedge clk) disable iff (rst)
    op == OP_STRIKE |-> SQ_W'(jj) >= sq)
    else $error("strike below candidate square");

endmodule

/* sv/sieve_trial_division_prime_test.sv */
// ----------------------------------------------------------------------------
// sieve_trial_division_prime_test
// Primality test of a 31-bit number by trial division over a bit sieve.
// ----------------------------------------------------------------------------
// One item at a time. For a number n with c = ceil(sqrt(n)) an item runs
// the root and the sieve refill, a read of each candidate from 2 to c, a
// bit-serial remainder (one bit a cycle) for each candidate still unmarked,
// and a striking pass over the multiples of each passing candidate from
// its square up to c: the sieve memory and the serial remainder set the
// pace, and an item takes longer when the sieve is cut short, as every
// candidate beyond it is divided. The result register lets the next item
// in while a result waits to be taken.
module sieve_trial_division_prime_test
  import stdpt_pkg::*;
#(
  parameter int SIEVE_DEPTH = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [30:0] number
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata    // [0] is_prime
);

  op_t   op;
  stat_t stat;
  logic  is_prime;

  stdpt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .op       (op)
  );

  stdpt_dpath #(
    .SIEVE_DEPTH (SIEVE_DEPTH)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .op       (op),
    .stat     (stat),
    .number   (s_tdata[NUM_W-1:0]),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .is_prime (is_prime)
  );

  assign m_tdata = {7'b0, is_prime};

endmodule

/* dv/tb_sieve_trial_division_prime_test.sv */
// ----------------------------------------------------------------------------
// tb_sieve_trial_division_prime_test
// Streams numbers into the sieve prime tester and checks each is_prime flag
// against a local trial-division predictor with its own sieve. The block is
// built with a reduced sieve so that the largest numbers also try
// candidates that lie beyond the sieve.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_sieve_trial_division_prime_test
  import stdpt_pkg::*;
();

  // below ceil(sqrt(2^31-1)) = 46341, so top-end numbers run past the sieve
  localparam int SIEVE_DEPTH = 46000;

  typedef struct {
    logic [NUM_W-1:0] number;
    logic             is_prime;
  } verdict_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // [30:0] number
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;        // [0] is_prime

  logic [NUM_W-1:0] number_q[$];
  verdict_t         verdict_q[$];
  verdict_t         oldest;
  bit               struck_map [SIEVE_DEPTH];
  int               item_total = 0;
  int               items_in = 0;
  int               mismatches = 0;
  int               send_idle_pct;
  int               recv_idle_pct;

  sieve_trial_division_prime_test #(
    .SIEVE_DEPTH(SIEVE_DEPTH)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  // idling by thirds of the run: receiver-heavy, sender-heavy, then none
  assign send_idle_pct = (items_in * 3 < item_total) ? 30 :
                         (items_in * 3 < 2 * item_total) ? 55 : 0;
  assign recv_idle_pct = (items_in * 3 < item_total) ? 55 :
                         (items_in * 3 < 2 * item_total) ? 30 : 0;

  function automatic int unsigned root_ceiling(logic [NUM_W-1:0] v);
    int unsigned r;
    int unsigned t;
    r = 0;
    for (int b = 15; b >= 0; b--) begin
      t = r | (32'd1 << b);
      if (longint'(t) * longint'(t) <= longint'(v)) r = t;
    end
    if (longint'(r) * longint'(r) < longint'(v)) r++;
    return r;
  endfunction

  // candidates at or above the sieve depth have no mark and are always tried
  function automatic logic is_prime_of(logic [NUM_W-1:0] num);
    int unsigned lim;
    logic        verdict;
    longint      j;
    lim = root_ceiling(num);
    verdict = 1'b0;
    foreach (struck_map[k]) struck_map[k] = 1'b0;
    for (int unsigned i = 2; i <= lim; i++) begin
      if (i < SIEVE_DEPTH && struck_map[i]) continue;
      if (num % i == 0 && num != i) begin
        verdict = 1'b0;
        break;
      end
      verdict = 1'b1;
      for (j = longint'(i) * i; j <= lim && j < SIEVE_DEPTH; j += i)
        struck_map[j] = 1'b1;
    end
    return verdict;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (s_tvalid) begin
        verdict_q.push_back('{s_tdata[NUM_W-1:0], is_prime_of(s_tdata[NUM_W-1:0])});
        items_in++;
      end
      if (number_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, number_q.pop_front()};
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (verdict_q.size() == 0) begin
          $error("is_prime: expected no item, actual %0b", m_tdata[0]);
          mismatches++;
        end else begin
          oldest = verdict_q.pop_front();
          if (m_tdata[0] !== oldest.is_prime) begin
            $error("is_prime for %0d: expected %0b, actual %0b",
                   oldest.number, oldest.is_prime, m_tdata[0]);
            mismatches++;
          end
        end
      end
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    int unsigned big_a;
    int unsigned big_b;
    int unsigned pick;
    logic [NUM_W-1:0] n;

    // zero, one, two, small primes and prime squares, field extremes,
    // a prime running past the sieve, a divisor found beyond the sieve
    number_q = '{0, 1, 2, 3, 4, 5, 9, 25, 49, 97, 121, 65521, 65535,
                 1073741824, 2147483646, 2147483647, 2147117569};
    big_a = $urandom_range(99);
    big_b = $urandom_range(99);
    for (int i = 0; i < 100; i++) begin
      pick = $urandom_range(99);
      if (i == big_a || i == big_b)
        n = NUM_W'($urandom());
      else if (pick < 8)
        n = NUM_W'($urandom_range(3));
      else if (pick < 20)
        n = NUM_W'($urandom_range(32'h00FF_FFFF));
      else
        n = NUM_W'($urandom_range(32'h0000_FFFF));
      number_q.push_back(n);
    end
    item_total = number_q.size();

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (items_in != item_total) @(posedge clk);
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
